// ===== design/vzp_pkg.sv =====
// Shared types, codes and the step plan of the viewport zoom/pan/clamp block.
package vzp_pkg;

	localparam int ZOOM_W = 14;   // zoom register width
	localparam int ZDIV_W = 15;   // divisor width (one bit wider than the zoom, holds twice the zoom)

	typedef enum logic [2:0] {
		OP_INIT = 3'd0,
		OP_ZOOM = 3'd1,
		OP_PAN  = 3'd2,
		OP_W2S  = 3'd3,
		OP_S2W  = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		CFG_WIDTH   = 2'd0,
		CFG_HEIGHT  = 2'd1,
		CFG_FLOOR   = 2'd2,
		CFG_CEILING = 2'd3
	} cfg_idx_t;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_ISSUE = 5'b00010,
		S_WAIT  = 5'b00100,
		S_MUL   = 5'b01000,
		S_OUT   = 5'b10000
	} state_t;

	typedef enum logic [2:0] {
		MOP_TW,   // screen to world on one axis (one divide)
		MOP_CL,   // clamp one axis (one divide for the half window)
		MOP_TS,   // world to screen on one axis (one multiply)
		MOP_NZ,   // new zoom
		MOP_END
	} mop_t;

	typedef struct packed {
		mop_t mop;
		logic axis;   // 0 x, 1 y
	} plan_t;

	// Micro step for a given operation and step index.
	function automatic plan_t plan(input logic [2:0] op, input logic [3:0] ph);
		plan_t p;
		p.mop  = MOP_END;
		p.axis = 1'b0;
		unique case (op)
			OP_INIT, OP_PAN: begin
				if (ph < 4'd2) begin
					p.mop  = MOP_CL;
					p.axis = ph[0];
				end
			end
			OP_ZOOM: begin
				unique case (ph)
					4'd0: p = '{MOP_TW, 1'b0};
					4'd1: p = '{MOP_TW, 1'b1};
					4'd2: p = '{MOP_NZ, 1'b0};
					4'd3: p = '{MOP_CL, 1'b0};
					4'd4: p = '{MOP_CL, 1'b1};
					4'd5: p = '{MOP_TW, 1'b0};
					4'd6: p = '{MOP_TW, 1'b1};
					4'd7: p = '{MOP_CL, 1'b0};
					4'd8: p = '{MOP_CL, 1'b1};
					default: p = '{MOP_END, 1'b0};
				endcase
			end
			OP_W2S: begin
				if (ph < 4'd2) begin
					p.mop  = MOP_TS;
					p.axis = ph[0];
				end
			end
			OP_S2W: begin
				if (ph < 4'd2) begin
					p.mop  = MOP_TW;
					p.axis = ph[0];
				end
			end
			default: p = '{MOP_END, 1'b0};
		endcase
		return p;
	endfunction

endpackage

// ===== design/vzp_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
module vzp_div #(
	parameter int DIVIDEND_W = 38
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [DIVIDEND_W-1:0]         dividend,
	input  logic [vzp_pkg::ZDIV_W-1:0]    divisor,
	output logic                          busy,
	output logic                          done,
	output logic [DIVIDEND_W-1:0]         quotient
);

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic [vzp_pkg::ZDIV_W-1:0] rem_q;
	logic [vzp_pkg::ZDIV_W-1:0] dsr_q;
	logic [DIVIDEND_W-1:0]      quo_q;
	logic [CNT_W-1:0]           cnt_q;
	logic                       busy_q;
	logic                       done_q;
	logic [vzp_pkg::ZDIV_W:0]   trial;
	logic                       fits;

	// trial subtract of the divisor from the shifted remainder
	assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	// control: count bits, flag the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: shift dividend bits in, quotient bits out
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? vzp_pkg::ZDIV_W'(trial - {1'b0, dsr_q})
			              : vzp_pkg::ZDIV_W'(trial);
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ===== design/viewport_zoom_pan_clamp.sv =====
// Top level of the viewport zoom/pan/clamp block: sequencer, state and datapath.
//
// Channel | Direction | Handshake           | Word
// in      | input     | in_valid / in_stall | op, coord_x, coord_y, zoom_delta
// out     | output    | out_valid/out_stall | point_x/y, zoom_now, center_x/y_now, can_pan
// cfg     | input     | cfg_we              | cfg_index, cfg_data
//
// One shared restoring divider, one bit per cycle, serves every divide; each is issued from
// S_ISSUE and collected in S_WAIT. The dividend is ZOOM_FRAC_BITS + 26 bits wide.
// Initialize and screen-to-world use two divides, pan up to two, zoom up to eight.
// Reset clears the sequencer and loads the default registers and view.
// in_stall stays high from acceptance until the result is in the output register;
// a stalled output word holds while the next input word is taken.
module viewport_zoom_pan_clamp #(
	parameter int COORD_FRAC_BITS = 8,
	parameter int ZOOM_FRAC_BITS  = 12
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         op,
	input  logic signed [23:0] coord_x,
	input  logic signed [23:0] coord_y,
	input  logic signed [15:0] zoom_delta,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [23:0] point_x,
	output logic signed [23:0] point_y,
	output logic [13:0]        zoom_now,
	output logic [19:0]        center_x_now,
	output logic [19:0]        center_y_now,
	output logic               can_pan,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [13:0]        cfg_data
);

	localparam int DW  = ZOOM_FRAC_BITS + 26;   // divide magnitude width
	localparam int WW  = DW + 3;                 // signed working width
	localparam int DFW = 27;                     // world minus center
	localparam int PW  = DFW + vzp_pkg::ZDIV_W;  // product width
	localparam int ZW  = vzp_pkg::ZOOM_W;
	localparam logic [31:0] PAN_THR = 32'((1001 * (1 << ZOOM_FRAC_BITS)) / 1000);
	localparam logic signed [WW-1:0] RST_CX  = WW'((640 << COORD_FRAC_BITS) / 2);
	localparam logic signed [WW-1:0] RST_CY  = WW'((480 << COORD_FRAC_BITS) / 2);
	localparam logic signed [WW-1:0] SAT_HI  = WW'(8388607);
	localparam logic signed [WW-1:0] SAT_LO  = WW'(-8388608);
	localparam logic signed [PW-1:0] RND_ADD = PW'((1 << ZOOM_FRAC_BITS) - 1);

	function automatic logic signed [23:0] sat24(input logic signed [WW-1:0] v);
		logic signed [23:0] r;
		if (v > SAT_HI)
			r = 24'sh7FFFFF;
		else if (v < SAT_LO)
			r = 24'sh800000;
		else
			r = v[23:0];
		return r;
	endfunction

	// registers and state
	logic [11:0]              width_q, height_q;
	logic [ZW-1:0]            floor_q, ceil_q, zoom_q;
	logic signed [WW-1:0]     cx_q, cy_q, bx_q, by_q;
	vzp_pkg::state_t          state_q;
	logic [3:0]               ph_q;
	logic [2:0]               op_q;
	logic signed [23:0]       x_q, y_q;
	logic signed [15:0]       dz_q;
	logic                     neg_q;
	logic signed [PW-1:0]     prod_q;
	logic signed [23:0]       px_q, py_q;
	logic                     out_valid_q;
	logic signed [23:0]       opx_q, opy_q;
	logic [ZW-1:0]            ozoom_q;
	logic [19:0]              ocx_q, ocy_q;
	logic                     opan_q;

	// datapath signals
	vzp_pkg::plan_t           pl;
	logic [11:0]              size_a;
	logic signed [WW-1:0]     c_a, b_a, full_a, mid_a, s_a, tw_d, tw_mag;
	logic                     tw_neg;
	logic [ZW-1:0]            zd;
	logic                     div_start, div_busy, div_done;
	logic [DW-1:0]            div_dividend, div_quo;
	logic [vzp_pkg::ZDIV_W-1:0] div_divisor;
	logic signed [WW-1:0]     qs, tw, half, hi, cl;
	logic signed [DFW-1:0]    ts_diff;
	logic signed [PW-1:0]     ts_adj, ts_sh;
	logic signed [WW-1:0]     ts;
	logic signed [17:0]       nz_sum, nz;
	logic                     pan_ok;
	logic                     accept, load_out;

	assign accept = in_valid && !in_stall;
	assign pan_ok = 32'(zoom_q) > PAN_THR;
	assign pl     = vzp_pkg::plan(op_q, ph_q);

	// select the axis operands
	always_comb begin
		size_a = pl.axis ? height_q : width_q;
		c_a    = pl.axis ? cy_q : cx_q;
		b_a    = pl.axis ? by_q : bx_q;
		s_a    = pl.axis ? WW'(y_q) : WW'(x_q);
		full_a = WW'(size_a) <<< COORD_FRAC_BITS;
		mid_a  = full_a >>> 1;
		zd     = (zoom_q == '0) ? ZW'(1) : zoom_q;
		tw_d   = s_a - mid_a;
		tw_neg = tw_d[WW-1];
		tw_mag = tw_neg ? -tw_d : tw_d;
	end

	// feed the shared divider
	always_comb begin
		div_start = (state_q == vzp_pkg::S_ISSUE) &&
			((pl.mop == vzp_pkg::MOP_TW) || (pl.mop == vzp_pkg::MOP_CL));
		if (pl.mop == vzp_pkg::MOP_CL) begin
			div_dividend = DW'(full_a <<< ZOOM_FRAC_BITS);
			div_divisor  = {zd, 1'b0};
		end else begin
			div_dividend = DW'(tw_mag <<< ZOOM_FRAC_BITS);
			div_divisor  = {1'b0, zd};
		end
	end

	vzp_div #(
		.DIVIDEND_W(DW)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(div_dividend),
		.divisor (div_divisor),
		.busy    (div_busy),
		.done    (div_done),
		.quotient(div_quo)
	);

	// finish the divide: signed quotient, mapped point, clamped center
	always_comb begin
		qs   = neg_q ? -WW'(div_quo) : WW'(div_quo);
		tw   = qs + c_a;
		half = WW'(div_quo);
		hi   = full_a - half;
		priority if (hi <= half)
			cl = mid_a;
		else if (c_a < half)
			cl = half;
		else if (c_a > hi)
			cl = hi;
		else
			cl = c_a;
	end

	// world to screen: truncate the product toward zero
	always_comb begin
		ts_diff = DFW'(s_a) - DFW'(c_a);
		ts_adj  = prod_q + (prod_q[PW-1] ? RND_ADD : '0);
		ts_sh   = ts_adj >>> ZOOM_FRAC_BITS;
		ts      = WW'(ts_sh) + mid_a;
	end

	// new zoom with floor first, then ceiling
	always_comb begin
		nz_sum = 18'(signed'({1'b0, zoom_q})) + 18'(dz_q);
		priority if (nz_sum < 18'(signed'({1'b0, floor_q})))
			nz = 18'(signed'({1'b0, floor_q}));
		else if (nz_sum > 18'(signed'({1'b0, ceil_q})))
			nz = 18'(signed'({1'b0, ceil_q}));
		else
			nz = nz_sum;
	end

	assign load_out = (state_q == vzp_pkg::S_OUT) && (!out_valid_q || !out_stall);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 12'd640;
			height_q <= 12'd480;
			floor_q  <= ZW'(4096);
			ceil_q   <= ZW'(14336);
		end else if (cfg_we) begin
			unique case (vzp_pkg::cfg_idx_t'(cfg_index))
				vzp_pkg::CFG_WIDTH:   width_q  <= cfg_data[11:0];
				vzp_pkg::CFG_HEIGHT:  height_q <= cfg_data[11:0];
				vzp_pkg::CFG_FLOOR:   floor_q  <= cfg_data;
				vzp_pkg::CFG_CEILING: ceil_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and view state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vzp_pkg::S_IDLE;
			ph_q    <= '0;
			cx_q    <= RST_CX;
			cy_q    <= RST_CY;
			zoom_q  <= ZW'(4096);
		end else begin
			unique case (state_q)
				vzp_pkg::S_IDLE: begin
					if (accept) begin
						ph_q    <= '0;
						state_q <= vzp_pkg::S_ISSUE;
						unique case (op)
							vzp_pkg::OP_INIT: begin
								cx_q   <= (WW'(width_q) <<< COORD_FRAC_BITS) >>> 1;
								cy_q   <= (WW'(height_q) <<< COORD_FRAC_BITS) >>> 1;
								zoom_q <= floor_q;
							end
							vzp_pkg::OP_ZOOM: begin
								if (zoom_delta == '0)
									state_q <= vzp_pkg::S_OUT;
							end
							vzp_pkg::OP_PAN: begin
								if (pan_ok && (coord_x != '0 || coord_y != '0)) begin
									cx_q <= cx_q + WW'(coord_x);
									cy_q <= cy_q + WW'(coord_y);
								end else begin
									state_q <= vzp_pkg::S_OUT;
								end
							end
							vzp_pkg::OP_W2S, vzp_pkg::OP_S2W: ;
							default: state_q <= vzp_pkg::S_OUT;
						endcase
					end
				end
				vzp_pkg::S_ISSUE: begin
					unique case (pl.mop)
						vzp_pkg::MOP_TW, vzp_pkg::MOP_CL: state_q <= vzp_pkg::S_WAIT;
						vzp_pkg::MOP_TS: state_q <= vzp_pkg::S_MUL;
						vzp_pkg::MOP_NZ: begin
							if (ZW'(nz) == zoom_q) begin
								state_q <= vzp_pkg::S_OUT;
							end else begin
								zoom_q <= ZW'(nz);
								ph_q   <= ph_q + 1'b1;
							end
						end
						default: state_q <= vzp_pkg::S_OUT;
					endcase
				end
				vzp_pkg::S_WAIT: begin
					if (div_done) begin
						ph_q    <= ph_q + 1'b1;
						state_q <= vzp_pkg::S_ISSUE;
						if (pl.mop == vzp_pkg::MOP_CL) begin
							if (pl.axis) cy_q <= cl;
							else         cx_q <= cl;
						end else if (op_q == vzp_pkg::OP_ZOOM && ph_q > 4'd4) begin
							if (pl.axis) cy_q <= b_a - qs;
							else         cx_q <= b_a - qs;
						end
					end
				end
				vzp_pkg::S_MUL: begin
					ph_q    <= ph_q + 1'b1;
					state_q <= vzp_pkg::S_ISSUE;
				end
				vzp_pkg::S_OUT: begin
					if (load_out)
						state_q <= vzp_pkg::S_IDLE;
				end
				default: state_q <= vzp_pkg::S_IDLE;
			endcase
		end
	end

	// item word, operands and points
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= op;
			x_q  <= coord_x;
			y_q  <= coord_y;
			dz_q <= zoom_delta;
			px_q <= '0;
			py_q <= '0;
		end
		if (div_start)
			neg_q <= (pl.mop == vzp_pkg::MOP_TW) && tw_neg;
		if (state_q == vzp_pkg::S_ISSUE && pl.mop == vzp_pkg::MOP_TS)
			prod_q <= PW'(ts_diff) * PW'(signed'({1'b0, zoom_q}));
		if (state_q == vzp_pkg::S_MUL) begin
			if (pl.axis) py_q <= sat24(ts);
			else         px_q <= sat24(ts);
		end
		if (state_q == vzp_pkg::S_WAIT && div_done && pl.mop == vzp_pkg::MOP_TW) begin
			if (op_q == vzp_pkg::OP_S2W) begin
				if (pl.axis) py_q <= sat24(tw);
				else         px_q <= sat24(tw);
			end else if (ph_q < 4'd2) begin
				if (pl.axis) by_q <= tw;
				else         bx_q <= tw;
			end
		end
	end

	// output register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			opx_q   <= px_q;
			opy_q   <= py_q;
			ozoom_q <= zoom_q;
			ocx_q   <= 20'(cx_q);
			ocy_q   <= 20'(cy_q);
			opan_q  <= pan_ok;
		end
	end

	assign in_stall     = (state_q != vzp_pkg::S_IDLE);
	assign out_valid    = out_valid_q;
	assign point_x      = opx_q;
	assign point_y      = opy_q;
	assign zoom_now     = ozoom_q;
	assign center_x_now = ocx_q;
	assign center_y_now = ocy_q;
	assign can_pan      = opan_q;

`ifndef ASSERT_OFF
	// the divider runs only while the sequencer waits on it
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_busy |-> (state_q == vzp_pkg::S_WAIT))
		else $error("divider busy outside wait");

	// an accepted word keeps the block busy in the next cycle
	a_busy_after: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("input taken while busy");

	// between items the center is never negative
	a_center_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == vzp_pkg::S_IDLE) |-> (!cx_q[WW-1] && !cy_q[WW-1]))
		else $error("center out of range when idle");
`endif

endmodule
